// ===== rtl/sgr_pkg.sv =====
// Shared types, code points and field widths of the SGR pen interpreter.
package sgr_pkg;

    localparam int PARAM_W = 15;

    // Extended colour progress between parameters
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_KIND     = 3'd1,
        PH_INDEX    = 3'd2,
        PH_RED_SKIP = 3'd3,
        PH_RED      = 3'd4,
        PH_GREEN    = 3'd5,
        PH_BLUE     = 3'd6
    } sgr_phase_t;

    localparam logic [1:0] KIND_DEFAULT = 2'd0;
    localparam logic [1:0] KIND_INDEXED = 2'd1;
    localparam logic [1:0] KIND_RGB     = 2'd2;

    // Attribute bit positions
    localparam int BIT_BOLD      = 0;
    localparam int BIT_DIM       = 1;
    localparam int BIT_ITALIC    = 2;
    localparam int BIT_UNDERLINE = 3;
    localparam int BIT_BLINK     = 4;
    localparam int BIT_REVERSE   = 5;
    localparam int BIT_INVISIBLE = 6;
    localparam int BIT_STRIKE    = 7;

    // SGR code points
    localparam logic [PARAM_W-1:0] CODE_RESET          = 15'd0;
    localparam logic [PARAM_W-1:0] CODE_BOLD           = 15'd1;
    localparam logic [PARAM_W-1:0] CODE_DIM            = 15'd2;
    localparam logic [PARAM_W-1:0] CODE_ITALIC         = 15'd3;
    localparam logic [PARAM_W-1:0] CODE_UNDERLINE      = 15'd4;
    localparam logic [PARAM_W-1:0] CODE_BLINK_SLOW     = 15'd5;
    localparam logic [PARAM_W-1:0] CODE_BLINK_FAST     = 15'd6;
    localparam logic [PARAM_W-1:0] CODE_REVERSE        = 15'd7;
    localparam logic [PARAM_W-1:0] CODE_INVISIBLE      = 15'd8;
    localparam logic [PARAM_W-1:0] CODE_STRIKE         = 15'd9;
    localparam logic [PARAM_W-1:0] CODE_DBL_UNDERLINE  = 15'd21;
    localparam logic [PARAM_W-1:0] CODE_NORMAL_INTENS  = 15'd22;
    localparam logic [PARAM_W-1:0] CODE_NO_ITALIC      = 15'd23;
    localparam logic [PARAM_W-1:0] CODE_NO_UNDERLINE   = 15'd24;
    localparam logic [PARAM_W-1:0] CODE_NO_BLINK       = 15'd25;
    localparam logic [PARAM_W-1:0] CODE_NO_REVERSE     = 15'd27;
    localparam logic [PARAM_W-1:0] CODE_NO_INVISIBLE   = 15'd28;
    localparam logic [PARAM_W-1:0] CODE_NO_STRIKE      = 15'd29;
    localparam logic [PARAM_W-1:0] CODE_FG_BASE        = 15'd30;
    localparam logic [PARAM_W-1:0] CODE_FG_LAST        = 15'd37;
    localparam logic [PARAM_W-1:0] CODE_FG_EXTENDED    = 15'd38;
    localparam logic [PARAM_W-1:0] CODE_FG_DEFAULT     = 15'd39;
    localparam logic [PARAM_W-1:0] CODE_BG_BASE        = 15'd40;
    localparam logic [PARAM_W-1:0] CODE_BG_LAST        = 15'd47;
    localparam logic [PARAM_W-1:0] CODE_BG_EXTENDED    = 15'd48;
    localparam logic [PARAM_W-1:0] CODE_BG_DEFAULT     = 15'd49;
    localparam logic [PARAM_W-1:0] CODE_FG_BRIGHT_BASE = 15'd90;
    localparam logic [PARAM_W-1:0] CODE_FG_BRIGHT_LAST = 15'd97;
    localparam logic [PARAM_W-1:0] CODE_BG_BRIGHT_BASE = 15'd100;
    localparam logic [PARAM_W-1:0] CODE_BG_BRIGHT_LAST = 15'd107;

    // Colour space selectors after 38/48
    localparam logic [PARAM_W-1:0] EXT_SPACE_INDEXED = 15'd5;
    localparam logic [PARAM_W-1:0] EXT_SPACE_RGB     = 15'd2;

    localparam logic [7:0] BRIGHT_OFFSET = 8'd8;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } sgr_colour_t;

    typedef struct packed {
        logic [7:0]  attributes;
        sgr_colour_t fg;
        sgr_colour_t bg;
        sgr_phase_t  phase;
        logic        target_bg;
        logic [15:0] staged_rg;
    } sgr_state_t;

    typedef struct packed {
        logic [PARAM_W-1:0] value;
        logic               empty;
        logic               colon;
        logic               last;
    } sgr_param_t;

endpackage

// ===== rtl/sgr_param_if.sv =====
// Parameter channel: one SGR parameter word per handshake.
interface sgr_param_if import sgr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PARAM_W-1:0] param_value;
    logic               param_empty;
    logic               colon_before;
    logic               last_param;

    modport source (output valid, output param_value, output param_empty,
                    output colon_before, output last_param, input ready);
    modport sink   (input valid, input param_value, input param_empty,
                    input colon_before, input last_param, output ready);
endinterface

// ===== rtl/sgr_pen_if.sv =====
// Pen channel: the full pen after each parameter, one word per handshake.
interface sgr_pen_if;
    logic       valid;
    logic       ready;
    logic [7:0] attributes;
    logic [1:0] fg_kind;
    logic [7:0] fg_index;
    logic [7:0] fg_red;
    logic [7:0] fg_green;
    logic [7:0] fg_blue;
    logic [1:0] bg_kind;
    logic [7:0] bg_index;
    logic [7:0] bg_red;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;
    logic       sequence_done;

    modport source (output valid, output attributes, output fg_kind, output fg_index,
                    output fg_red, output fg_green, output fg_blue, output bg_kind,
                    output bg_index, output bg_red, output bg_green, output bg_blue,
                    output sequence_done, input ready);
    modport sink   (input valid, input attributes, input fg_kind, input fg_index,
                    input fg_red, input fg_green, input fg_blue, input bg_kind,
                    input bg_index, input bg_red, input bg_green, input bg_blue,
                    input sequence_done, output ready);
endinterface

// ===== rtl/sgr_decode.sv =====
// Next pen and extended colour state for one SGR parameter.
module sgr_decode import sgr_pkg::*; (
    input  sgr_state_t cur,
    input  sgr_param_t param,
    output sgr_state_t nxt
);

    logic [PARAM_W-1:0] v;
    sgr_colour_t        dst;
    logic               dst_write;

    always_comb
    begin
        nxt       = cur;
        v         = param.empty ? '0 : param.value;
        dst       = cur.target_bg ? cur.bg : cur.fg;
        dst_write = 1'b0;

        case (cur.phase)
            PH_KIND:
            begin
                if (v == EXT_SPACE_INDEXED)
                begin
                    nxt.phase = PH_INDEX;
                end
                else if (v == EXT_SPACE_RGB)
                begin
                    nxt.phase = param.colon ? PH_RED_SKIP : PH_RED;
                end
                else
                begin
                    nxt.phase = PH_IDLE;
                end
            end
            PH_INDEX:
            begin
                dst.kind  = KIND_INDEXED;
                dst.index = v[7:0];
                dst_write = 1'b1;
                nxt.phase = PH_IDLE;
            end
            PH_RED_SKIP:
            begin
                // colon form: drop one empty colour-space slot
                if (param.empty)
                begin
                    nxt.phase = PH_RED;
                end
                else
                begin
                    nxt.staged_rg = {v[7:0], 8'h00};
                    nxt.phase     = PH_GREEN;
                end
            end
            PH_RED:
            begin
                nxt.staged_rg = {v[7:0], 8'h00};
                nxt.phase     = PH_GREEN;
            end
            PH_GREEN:
            begin
                nxt.staged_rg = {cur.staged_rg[15:8], v[7:0]};
                nxt.phase     = PH_BLUE;
            end
            PH_BLUE:
            begin
                dst.kind  = KIND_RGB;
                dst.red   = cur.staged_rg[15:8];
                dst.green = cur.staged_rg[7:0];
                dst.blue  = v[7:0];
                dst_write = 1'b1;
                nxt.phase = PH_IDLE;
            end
            default:
            begin
                nxt.phase = PH_IDLE;
                case (v)
                    CODE_RESET:
                    begin
                        nxt.fg.kind    = KIND_DEFAULT;
                        nxt.bg.kind    = KIND_DEFAULT;
                        nxt.attributes = '0;
                    end
                    CODE_BOLD:          nxt.attributes[BIT_BOLD]      = 1'b1;
                    CODE_DIM:           nxt.attributes[BIT_DIM]       = 1'b1;
                    CODE_ITALIC:        nxt.attributes[BIT_ITALIC]    = 1'b1;
                    CODE_UNDERLINE,
                    CODE_DBL_UNDERLINE: nxt.attributes[BIT_UNDERLINE] = 1'b1;
                    CODE_BLINK_SLOW,
                    CODE_BLINK_FAST:    nxt.attributes[BIT_BLINK]     = 1'b1;
                    CODE_REVERSE:       nxt.attributes[BIT_REVERSE]   = 1'b1;
                    CODE_INVISIBLE:     nxt.attributes[BIT_INVISIBLE] = 1'b1;
                    CODE_STRIKE:        nxt.attributes[BIT_STRIKE]    = 1'b1;
                    CODE_NORMAL_INTENS:
                    begin
                        nxt.attributes[BIT_BOLD] = 1'b0;
                        nxt.attributes[BIT_DIM]  = 1'b0;
                    end
                    CODE_NO_ITALIC:     nxt.attributes[BIT_ITALIC]    = 1'b0;
                    CODE_NO_UNDERLINE:  nxt.attributes[BIT_UNDERLINE] = 1'b0;
                    CODE_NO_BLINK:      nxt.attributes[BIT_BLINK]     = 1'b0;
                    CODE_NO_REVERSE:    nxt.attributes[BIT_REVERSE]   = 1'b0;
                    CODE_NO_INVISIBLE:  nxt.attributes[BIT_INVISIBLE] = 1'b0;
                    CODE_NO_STRIKE:     nxt.attributes[BIT_STRIKE]    = 1'b0;
                    CODE_FG_EXTENDED:
                    begin
                        nxt.target_bg = 1'b0;
                        nxt.phase     = PH_KIND;
                    end
                    CODE_BG_EXTENDED:
                    begin
                        nxt.target_bg = 1'b1;
                        nxt.phase     = PH_KIND;
                    end
                    CODE_FG_DEFAULT:    nxt.fg.kind = KIND_DEFAULT;
                    CODE_BG_DEFAULT:    nxt.bg.kind = KIND_DEFAULT;
                    default:
                    begin
                        if (v >= CODE_FG_BASE && v <= CODE_FG_LAST)
                        begin
                            nxt.fg.kind  = KIND_INDEXED;
                            nxt.fg.index = 8'(v - CODE_FG_BASE);
                        end
                        else if (v >= CODE_BG_BASE && v <= CODE_BG_LAST)
                        begin
                            nxt.bg.kind  = KIND_INDEXED;
                            nxt.bg.index = 8'(v - CODE_BG_BASE);
                        end
                        else if (v >= CODE_FG_BRIGHT_BASE && v <= CODE_FG_BRIGHT_LAST)
                        begin
                            nxt.fg.kind  = KIND_INDEXED;
                            nxt.fg.index = 8'(v - CODE_FG_BRIGHT_BASE) + BRIGHT_OFFSET;
                        end
                        else if (v >= CODE_BG_BRIGHT_BASE && v <= CODE_BG_BRIGHT_LAST)
                        begin
                            nxt.bg.kind  = KIND_INDEXED;
                            nxt.bg.index = 8'(v - CODE_BG_BRIGHT_BASE) + BRIGHT_OFFSET;
                        end
                    end
                endcase
            end
        endcase

        if (dst_write)
        begin
            if (cur.target_bg)
            begin
                nxt.bg = dst;
            end
            else
            begin
                nxt.fg = dst;
            end
        end

        // a sequence end drops any unfinished extended colour
        if (param.last)
        begin
            nxt.phase = PH_IDLE;
        end
    end

endmodule

// ===== rtl/sgr_pen_attribute_interpreter.sv =====
// Top level of the SGR pen interpreter: input register, decode, pen register.
//
// Feed the parameters of an SGR sequence one word per handshake on the param
// channel; for every parameter exactly one pen word comes out on the pen
// channel, holding the eight attribute bits, the foreground and background
// colour (kind, palette index, RGB) and sequence_done, a copy of last_param.
// An empty sequence is one empty parameter and resets the pen. 38/48 take
// 5;n for an indexed colour and 2;r;g;b for truecolour; in the colon form one
// empty colour-space slot after the 2 is skipped, and a sequence that ends
// before the colour is complete leaves the colour unchanged. Index and RGB
// fields always show the stored values, also when the kind ignores them.
// Timing: one word per cycle sustained while the pen channel takes every word;
// the pen word for a parameter passes the input register, then the pen
// register, before it is valid on the pen channel. The pen state update is
// combinational decode logic, so consecutive parameters can enter back to
// back. While a pen word waits to be taken, the input register takes one
// more parameter and then holds ready low until the pen register frees up.
module sgr_pen_attribute_interpreter import sgr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    sgr_param_if.sink   param,
    sgr_pen_if.source   pen
);

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    sgr_param_t in_word_reg;

    // pen state and result register
    sgr_state_t state_reg;
    sgr_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    sgr_state_t out_pen_reg;
    logic       out_done_reg;

    logic out_free;
    logic advance;
    logic accept;

    sgr_param_t in_word;

    assign in_word = '{value: param.param_value,
                       empty: param.param_empty,
                       colon: param.colon_before,
                       last:  param.last_param};

    // The pen register frees up when empty or when its word is taken this cycle.
    assign out_free    = !out_valid_reg || pen.ready;
    assign advance     = in_valid_reg && out_free;
    assign param.ready = !in_valid_reg || out_free;
    assign accept      = param.valid && param.ready;

    sgr_decode u_decode (
        .cur   (state_reg),
        .param (in_word_reg),
        .nxt   (state_next)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pen.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and pen state: reset to default pen, idle phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{attributes: '0,
                               fg:         '{kind: KIND_DEFAULT, default: '0},
                               bg:         '{kind: KIND_DEFAULT, default: '0},
                               phase:      PH_IDLE,
                               target_bg:  1'b0,
                               staged_rg:  '0};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload: hold until the stage moves.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg <= in_word;
        end
        if (advance)
        begin
            out_pen_reg  <= state_next;
            out_done_reg <= in_word_reg.last;
        end
    end

    assign pen.valid         = out_valid_reg;
    assign pen.attributes    = out_pen_reg.attributes;
    assign pen.fg_kind       = out_pen_reg.fg.kind;
    assign pen.fg_index      = out_pen_reg.fg.index;
    assign pen.fg_red        = out_pen_reg.fg.red;
    assign pen.fg_green      = out_pen_reg.fg.green;
    assign pen.fg_blue       = out_pen_reg.fg.blue;
    assign pen.bg_kind       = out_pen_reg.bg.kind;
    assign pen.bg_index      = out_pen_reg.bg.index;
    assign pen.bg_red        = out_pen_reg.bg.red;
    assign pen.bg_green      = out_pen_reg.bg.green;
    assign pen.bg_blue       = out_pen_reg.bg.blue;
    assign pen.sequence_done = out_done_reg;

endmodule
